[hdl/trsb_pkg.sv]
package trsb_pkg;

  localparam int MaxPixels     = 16384;
  localparam int HistoryFrames = 32;
  localparam int Channels      = 3;
  localparam int PixAw         = $clog2(MaxPixels);
  localparam int SlotW         = $clog2(HistoryFrames);
  localparam int RowW          = Channels * HistoryFrames * 8;
  localparam int LenW          = 6;
  localparam int SumW          = 14;
  localparam int RecipShift    = 20;
  localparam int RecipW        = RecipShift + 1;
  localparam logic [3:0] BlendReset = 4'd4;

  // ceil(2^20 / len); exact truncating quotient for sum <= 255 * len, len <= 45.
  function automatic logic [RecipW-1:0] recip(input logic [LenW-1:0] len);
    logic [RecipW-1:0] r;
    r = '0;
    case (len)
      6'd1:  r = 21'd1048576;  6'd2:  r = 21'd524288;  6'd3:  r = 21'd349526;
      6'd4:  r = 21'd262144;   6'd5:  r = 21'd209716;  6'd6:  r = 21'd174763;
      6'd7:  r = 21'd149797;   6'd8:  r = 21'd131072;  6'd9:  r = 21'd116509;
      6'd10: r = 21'd104858;   6'd11: r = 21'd95326;   6'd12: r = 21'd87382;
      6'd13: r = 21'd80660;    6'd14: r = 21'd74899;   6'd15: r = 21'd69906;
      6'd16: r = 21'd65536;    6'd17: r = 21'd61681;   6'd18: r = 21'd58255;
      6'd19: r = 21'd55189;    6'd20: r = 21'd52429;   6'd21: r = 21'd49933;
      6'd22: r = 21'd47663;    6'd23: r = 21'd45591;   6'd24: r = 21'd43691;
      6'd25: r = 21'd41944;    6'd26: r = 21'd40330;   6'd27: r = 21'd38837;
      6'd28: r = 21'd37450;    6'd29: r = 21'd36158;   6'd30: r = 21'd34953;
      6'd31: r = 21'd33826;    6'd32: r = 21'd32768;   6'd33: r = 21'd31776;
      6'd34: r = 21'd30841;    6'd35: r = 21'd29960;   6'd36: r = 21'd29128;
      6'd37: r = 21'd28340;    6'd38: r = 21'd27595;   6'd39: r = 21'd26887;
      6'd40: r = 21'd26215;    6'd41: r = 21'd25576;   6'd42: r = 21'd24967;
      6'd43: r = 21'd24386;    6'd44: r = 21'd23832;   6'd45: r = 21'd23302;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

[hdl/temporal_rgb_streak_blend.sv]
// Per-pixel temporal blend over a ring of 32 frames.
// Input stream s_*: one request per pixel. s_tdata holds, from bit 0 up, blue_in,
// green_in, red_in and pixel_index; s_tlast marks the last pixel of a frame,
// after which the ring slot advances.
// Output stream m_*: one result per request. m_tdata holds, from bit 0 up,
// blue_out, green_out and red_out: the truncated mean of the pixel and its
// previous frames over blend_count, 2*blend_count and 3*blend_count frames.
// blend_count is written through cfg_we / cfg_wdata; the user must do so only while
// the block is idle, which the block itself does not enforce. Each pixel passes from
// acceptance to a loaded output register through S_SUM1, S_SUM2 and S_MUL: its
// history row is read at acceptance, then come a write-back with partial sums, a final
// sum and a reciprocal multiply. The sequential controller around the single-port
// history RAM takes a new request only once the last has loaded the output register.
// After reset the history RAM is cleared one row per cycle, s_tready low, cfg writes taken.
// When the receiver stalls, the result stays in the output register; one more
// request can be processed and then waits until the register is free.
module temporal_rgb_streak_blend (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // blue_in, green_in, red_in, pixel_index, zero pad
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // blue_out, green_out, red_out
  input  logic        cfg_we,
  input  logic [3:0]  cfg_wdata
);

  localparam int Aw = trsb_pkg::PixAw;
  localparam int Hf = trsb_pkg::HistoryFrames;
  localparam int Sw = trsb_pkg::SlotW;
  localparam int Lw = trsb_pkg::LenW;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SUM1 = 4'b0010,
    S_SUM2 = 4'b0100,
    S_MUL  = 4'b1000
  } state_t;

  state_t state;
  logic [3:0]  blend_count;
  logic [Sw-1:0] frame_slot;
  logic [Aw:0] clr_cnt;
  logic        clearing;

  logic [7:0]    pix_b, pix_g, pix_r;
  logic [Aw-1:0] pix_addr;
  logic          pix_last;
  logic [Lw-1:0] len [3];

  logic                      ram_we;
  logic [Aw-1:0]             ram_addr;
  logic [trsb_pkg::RowW-1:0] ram_wdata, ram_rdata, new_row;

  logic [12:0] part_next [3][4];
  logic [12:0] part      [3][4];
  logic [trsb_pkg::SumW-1:0] sum [3];
  logic [7:0]  quot [3];
  logic        accept, out_load;

  assign clearing = !clr_cnt[Aw];
  assign s_tready = (state == S_IDLE) && !clearing;
  assign accept   = s_tvalid && s_tready;
  assign out_load = (state == S_MUL) && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      blend_count <= trsb_pkg::BlendReset;
    end else if (cfg_we) begin
      blend_count <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (clearing) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  // Window lengths; a zero count behaves as one.
  always_comb begin
    logic [Lw-1:0] n;
    n = (blend_count == 4'd0) ? Lw'(1) : Lw'(blend_count);
    len[0] = n;
    len[1] = Lw'(n << 1);
    len[2] = Lw'(n + (n << 1));
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pix_b    <= s_tdata[7:0];
      pix_g    <= s_tdata[15:8];
      pix_r    <= s_tdata[23:16];
      pix_addr <= s_tdata[24 +: Aw];
      pix_last <= s_tlast;
    end
  end

  // Merge the new pixel into its row at the current slot.
  always_comb begin
    new_row = ram_rdata;
    new_row[(0 * Hf + frame_slot) * 8 +: 8] = pix_b;
    new_row[(1 * Hf + frame_slot) * 8 +: 8] = pix_g;
    new_row[(2 * Hf + frame_slot) * 8 +: 8] = pix_r;
  end

  always_comb begin
    ram_we    = clearing || (state == S_SUM1);
    ram_addr  = clearing ? clr_cnt[Aw-1:0] : ((state == S_IDLE) ? s_tdata[24 +: Aw] : pix_addr);
    ram_wdata = clearing ? '0 : new_row;
  end

  trsb_ram #(
    .Width(trsb_pkg::RowW),
    .Depth(trsb_pkg::MaxPixels)
  ) u_hist (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(ram_wdata),
    .rdata(ram_rdata)
  );

  // A slot at distance d behind the current one counts once if d < len and
  // again if the window wraps past the whole ring.
  always_comb begin
    logic [Sw-1:0] d;
    logic [9:0]    v;
    logic [7:0]    b;
    for (int c = 0; c < 3; c++) begin
      for (int g = 0; g < 4; g++) begin
        part_next[c][g] = '0;
        for (int k = 0; k < 8; k++) begin
          d = Sw'(frame_slot - Sw'(g * 8 + k));
          b = new_row[(c * Hf + g * 8 + k) * 8 +: 8];
          v = '0;
          if (Lw'(d) < len[c]) v = {2'b00, b};
          if ((Lw'(d) + Lw'(Hf)) < len[c]) v = {1'b0, b, 1'b0};
          part_next[c][g] = part_next[c][g] + 13'(v);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_SUM1) part <= part_next;
    if (state == S_SUM2) begin
      for (int c = 0; c < 3; c++) begin
        sum[c] <= trsb_pkg::SumW'(part[c][0]) + trsb_pkg::SumW'(part[c][1]) +
                  trsb_pkg::SumW'(part[c][2]) + trsb_pkg::SumW'(part[c][3]);
      end
    end
  end

  always_comb begin
    logic [trsb_pkg::SumW+trsb_pkg::RecipW-1:0] prod;
    for (int c = 0; c < 3; c++) begin
      prod = sum[c] * trsb_pkg::recip(len[c]);
      quot[c] = prod[trsb_pkg::RecipShift +: 8];
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) m_tdata <= {quot[2], quot[1], quot[0]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      frame_slot <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      if (out_load) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
      unique case (state)
        S_IDLE: if (accept) state <= S_SUM1;
        S_SUM1: begin
          state <= S_SUM2;
          if (pix_last) frame_slot <= frame_slot + 1'b1;
        end
        S_SUM2: state <= S_MUL;
        S_MUL:  if (out_load) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !s_tready) else $error("request taken during history clear");

  a_accept_to_sum: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == S_SUM1) else $error("accepted request not processed");

  a_write_source: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (clearing || state == S_SUM1)) else $error("stray history write");

  a_load_valid: assert property (@(posedge clk) disable iff (rst)
    out_load |=> m_tvalid) else $error("loaded result not presented");

endmodule

[hdl/trsb_ram.sv]
module trsb_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

[sim/testbench.sv]
`timescale 1ns / 100ps

module testbench;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } rgb_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [39:0] s_tdata;   // blue_in, green_in, red_in, pixel_index, zero pad
  logic        s_tlast;
  logic        m_tvalid;
  logic        m_tready;
  logic [23:0] m_tdata;   // blue_out, green_out, red_out
  logic        cfg_we;
  logic [3:0]  cfg_wdata;

  temporal_rgb_streak_blend u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  // Shadow state of the blend.
  logic [7:0]       hist [trsb_pkg::Channels][trsb_pkg::MaxPixels][trsb_pkg::HistoryFrames];
  logic [trsb_pkg::SlotW-1:0] cur_slot;
  logic [3:0]       blend_cnt;

  rgb_t  pending_px[$];
  int    errors;
  int    cycles;
  int    pixels_sent;
  int    pixels_checked;
  int    send_idle_pct;
  int    recv_idle_pct;
  int    hold_cycles;
  int    hot_pix [8];

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 600000) begin
      $display("Timeout after %0d cycles", cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  // Receiver: random stalls plus an optional long hold-off.
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      m_tready = 1'b0;
      hold_cycles = hold_cycles - 1;
    end else begin
      m_tready = ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic report(input string field, input int got, input int want);
    $display("Mismatch on %s at result %0d: got %0d, expected %0d",
             field, pixels_checked, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    rgb_t got;
    rgb_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = rgb_t'({m_tdata[7:0], m_tdata[15:8], m_tdata[23:16]});
      if (pending_px.size() == 0) begin
        report("unexpected result", int'(m_tdata), 0);
      end else begin
        want = pending_px.pop_front();
        if (got.blue != want.blue)   report("blue", got.blue, want.blue);
        if (got.green != want.green) report("green", got.green, want.green);
        if (got.red != want.red)     report("red", got.red, want.red);
      end
      pixels_checked++;
    end
  end

  function automatic logic [7:0] window_avg(input int ch, input int pix, input int len);
    int sum;
    int pos;
    sum = hist[ch][pix][cur_slot];
    pos = (cur_slot + trsb_pkg::HistoryFrames - 1) % trsb_pkg::HistoryFrames;
    for (int j = 1; j < len; j++) begin
      sum += hist[ch][pix][pos];
      pos = (pos + trsb_pkg::HistoryFrames - 1) % trsb_pkg::HistoryFrames;
    end
    return 8'((sum / len) & 255);
  endfunction

  function automatic rgb_t blend_pixel(input logic [7:0] b, input logic [7:0] g,
                                       input logic [7:0] r,
                                       input logic [trsb_pkg::PixAw-1:0] pix,
                                       input logic last);
    rgb_t res;
    int   n;
    n = (blend_cnt == 0) ? 1 : blend_cnt;
    hist[0][pix][cur_slot] = b;
    hist[1][pix][cur_slot] = g;
    hist[2][pix][cur_slot] = r;
    res.blue  = window_avg(0, pix, n);
    res.green = window_avg(1, pix, 2 * n);
    res.red   = window_avg(2, pix, 3 * n);
    if (last) cur_slot = cur_slot + 1'b1;
    return res;
  endfunction

  task automatic send_pixel(input logic [7:0] b, input logic [7:0] g, input logic [7:0] r,
                            input logic [trsb_pkg::PixAw-1:0] pix, input logic last);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata  = {2'b00, pix, r, g, b};
    s_tlast  = last;
    do @(posedge clk); while (!s_tready);
    pending_px.push_back(blend_pixel(b, g, r, pix, last));
    pixels_sent++;
  endtask

  task automatic drain();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (pending_px.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic set_blend(input logic [3:0] v);
    drain();
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we    = 1'b0;
    blend_cnt = v;
  endtask

  task automatic test_directed();
    // Saturated and empty pixels at both ends of the index range.
    send_pixel(8'hFF, 8'hFF, 8'hFF, 14'd0, 1'b0);
    send_pixel(8'hFF, 8'hFF, 8'hFF, 14'h3FFF, 1'b1);
    send_pixel(8'h00, 8'h00, 8'h00, 14'd0, 1'b0);
    send_pixel(8'hAA, 8'h55, 8'hFF, 14'h3FFF, 1'b1);
    send_pixel(8'h55, 8'hAA, 8'h00, 14'h2AAA, 1'b1);
    // A zero blend count behaves as one, so the blue input passes straight through.
    set_blend(4'd0);
    for (int i = 0; i < 4; i++) send_pixel(8'(i * 60 + 15), 8'hFF, 8'h80, 14'h1555, 1'b1);
    set_blend(4'd1);
    for (int i = 0; i < 3; i++) send_pixel(8'hFF, 8'(i), 8'hFE, 14'd0, 1'b1);
    set_blend(4'd10);
    for (int i = 0; i < 5; i++) send_pixel(8'hFF, 8'hFF, 8'hFF, 14'h3FFF, 1'b1);
    // Windows longer than the ring wrap and count slots again.
    set_blend(4'd15);
    for (int i = 0; i < 5; i++) send_pixel(8'hFF, 8'hC3, 8'h3C, 14'h3FFF, i[0]);
  endtask

  task automatic test_frames(input int count, input int src_pct, input int dst_pct);
    int n;
    int fsize;
    logic [trsb_pkg::PixAw-1:0] pix;
    send_idle_pct = src_pct;
    recv_idle_pct = dst_pct;
    n = 0;
    while (n < count) begin
      fsize = $urandom_range(6, 1);
      for (int k = 0; k < fsize; k++) begin
        if ($urandom_range(9) == 0) pix = 14'($urandom_range(16383));
        else pix = 14'(hot_pix[$urandom_range(7)]);
        // Mostly clean frames; now and then a stray end marker or a missing one.
        send_pixel(8'($urandom), 8'($urandom), 8'($urandom), pix,
                   (k == fsize - 1) ? ($urandom_range(9) != 0) : ($urandom_range(19) == 0));
        n++;
      end
    end
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_cycles   = 300;
    for (int i = 0; i < 20; i++)
      send_pixel(8'($urandom), 8'($urandom), 8'($urandom), 14'(hot_pix[i % 8]), i[1]);
  endtask

  initial begin
    logic [3:0] v;
    errors = 0; cycles = 0; pixels_sent = 0; pixels_checked = 0;
    send_idle_pct = 0; recv_idle_pct = 0; hold_cycles = 0;
    s_tvalid = 1'b0; s_tdata = '0; s_tlast = 1'b0;
    m_tready = 1'b0; cfg_we = 1'b0; cfg_wdata = '0;
    cur_slot = '0; blend_cnt = trsb_pkg::BlendReset;
    for (int c = 0; c < trsb_pkg::Channels; c++)
      for (int p = 0; p < trsb_pkg::MaxPixels; p++)
        for (int f = 0; f < trsb_pkg::HistoryFrames; f++) hist[c][p][f] = 8'd0;
    hot_pix = '{0, 16383, 1, 8192, 5461, 10922, 12345, 4097};
    rst = 1'b1;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed();
    set_blend(4'd4);
    test_frames(170, 12, 73);
    v = 4'($urandom_range(10, 2));
    set_blend(v);
    test_frames(170, 73, 12);
    set_blend(4'd1);
    test_backpressure();
    set_blend(4'd10);
    test_frames(170, 0, 0);
    drain();

    $display("Covered %0d pixels and %0d results over blend counts 0, 1, 4, 10, 15 and %0d,",
             pixels_sent, pixels_checked, v);
    $display("with random stalls on both sides and a long output hold-off.");
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
